/* rtl/scc_pkg.sv */
// ---------------------------------------------------------------------------
// scc_pkg: shared types and constants for the SCC block
// Command and status structs between controller and datapath.
// ---------------------------------------------------------------------------
package scc_pkg;
  localparam int MaxVerticesDefault = 64;
  localparam int MaxEdgesDefault = 256;
  localparam int VertexWidth = 6;
  localparam int CountWidth = 7;
  localparam logic [CountWidth-1:0] CountReset = 7'd64;

  // Datapath operations requested by the controller
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_ROOT    = 4'd1,  // start search from root register
    OP_SCAN    = 4'd2,  // read edge at top's position
    OP_EDGE    = 4'd3,  // evaluate fetched edge
    OP_POP     = 4'd4,  // pop search stack (finish vertex)
    OP_NEXTV   = 4'd5,  // advance outer vertex
    OP_FPOP    = 4'd6,  // pop finish stack
    OP_CLEARV  = 4'd7,  // clear visited marks, reset outer loop
    OP_CLEARR  = 4'd8,  // clear run state
    OP_FREAD   = 4'd9,  // wait for finish stack read
    OP_TOPRD   = 4'd10  // wait for search stack read
  } op_t;

  typedef struct packed {
    op_t  op;
    logic reversed;
  } cmd_t;

  typedef struct packed {
    logic root_done;    // outer vertex at count
    logic root_visited;
    logic depth_zero;
    logic scan_end;     // position reached edge total
    logic edge_match;   // edge valid and leaves top
    logic next_visited;
    logic fstack_empty;
    logic ftop_ok;      // popped vertex is in range and unvisited
  } status_t;
endpackage

/* rtl/scc_if.sv */
// ---------------------------------------------------------------------------
// scc_if: valid/ready channel carrying a payload
// Generic source/sink channel used for all ports of the block.
// ---------------------------------------------------------------------------
interface scc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/scc_datapath.sv */
// ---------------------------------------------------------------------------
// scc_datapath: edge store, stacks and visited marks
// Executes one controller command per cycle; memories have registered reads.
// ---------------------------------------------------------------------------
module scc_datapath import scc_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDefault,
  parameter int MAX_EDGES = MaxEdgesDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   load_en,
  input  logic [VertexWidth-1:0] load_src,
  input  logic [VertexWidth-1:0] load_dst,
  input  logic                   load_has,
  input  logic [CountWidth-1:0]  vertex_count,
  output logic                   emit,
  output logic [VertexWidth-1:0] emit_vertex,
  output logic                   drop_flag
);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int DTW = $clog2(MAX_VERTICES + 1);

  logic [VertexWidth-1:0] from_mem [MAX_EDGES];
  logic [VertexWidth-1:0] to_mem [MAX_EDGES];
  logic [VertexWidth-1:0] fin_mem [MAX_VERTICES];
  logic [VertexWidth-1:0] sv_mem [MAX_VERTICES];
  logic [ETW-1:0]         sp_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited;

  logic [ETW-1:0] edge_total;
  logic [DTW-1:0] fsp;
  logic [DTW-1:0] depth;
  logic [CountWidth-1:0] outer;
  logic [CountWidth-1:0] cnt;
  logic [VertexWidth-1:0] top_v, fin_rd, ea, eb;
  logic [ETW-1:0] top_k;

  // Clamp count
  always_comb begin
    if (vertex_count > CountWidth'(MAX_VERTICES)) cnt = CountWidth'(MAX_VERTICES);
    else cnt = vertex_count;
  end

  logic [VertexWidth-1:0] here, nxt;
  logic ea_ok, eb_ok;
  assign here = cmd.reversed ? eb : ea;
  assign nxt = cmd.reversed ? ea : eb;
  assign ea_ok = {1'b0, ea} < cnt;
  assign eb_ok = {1'b0, eb} < cnt;

  // Status
  always_comb begin
    status.root_done = outer >= cnt;
    status.root_visited = visited[outer[VAW-1:0]];
    status.depth_zero = depth == '0;
    status.scan_end = top_k >= edge_total;
    status.edge_match = ea_ok && eb_ok && here == top_v;
    status.next_visited = visited[nxt[VAW-1:0]];
    status.fstack_empty = fsp == '0;
    status.ftop_ok = ({1'b0, fin_rd} < cnt) && !visited[fin_rd[VAW-1:0]];
  end

  // Edge loading
  logic load_ok;
  assign load_ok = ({1'b0, load_src} < cnt) && ({1'b0, load_dst} < cnt)
                   && (edge_total < ETW'(MAX_EDGES));
  always_ff @(posedge clk) begin
    if (load_en && load_has && load_ok) begin
      from_mem[edge_total[EAW-1:0]] <= load_src;
      to_mem[edge_total[EAW-1:0]] <= load_dst;
    end
    if (cmd.op == OP_SCAN) begin
      ea <= from_mem[top_k[EAW-1:0]];
      eb <= to_mem[top_k[EAW-1:0]];
    end
  end

  // Search stack memories: registered read of the top entry
  logic sv_we;
  logic [VAW-1:0] sv_wa;
  logic [VertexWidth-1:0] sv_wd;
  logic [ETW-1:0] sp_wd;
  logic [DTW-1:0] depth_next;
  logic [VertexWidth-1:0] push_v;
  logic do_push;
  always_comb begin
    sv_we = 1'b0;
    sv_wa = '0;
    sv_wd = '0;
    sp_wd = '0;
    depth_next = depth;
    push_v = '0;
    do_push = 1'b0;
    case (cmd.op)
      OP_ROOT: begin
        push_v = (cmd.reversed) ? fin_rd : outer[VertexWidth-1:0];
        sv_we = 1'b1; sv_wa = '0; sv_wd = push_v; depth_next = DTW'(1);
      end
      OP_EDGE: begin
        if (status.edge_match && !status.next_visited) begin
          do_push = 1'b1;
          sv_we = 1'b1;
          sv_wa = depth[VAW-1:0] - VAW'(1);
          sv_wd = top_v;
          sp_wd = top_k + ETW'(1);
          if (depth < DTW'(MAX_VERTICES)) depth_next = depth + DTW'(1);
        end
      end
      OP_POP: depth_next = depth - DTW'(1);
      default: ;
    endcase
  end

  // Write parent position back and child at depth
  logic child_we;
  logic [VAW-1:0] child_wa;
  always_ff @(posedge clk) begin
    if (sv_we) begin
      sv_mem[sv_wa] <= sv_wd;
      sp_mem[sv_wa] <= sp_wd;
    end
    if (child_we) begin
      sv_mem[child_wa] <= nxt;
      sp_mem[child_wa] <= '0;
    end
  end
  assign child_we = do_push && (depth < DTW'(MAX_VERTICES));
  assign child_wa = depth[VAW-1:0];

  // Top read: read after depth settles
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TOPRD) begin
      top_v <= sv_mem[depth[VAW-1:0] - VAW'(1)];
      top_k <= sp_mem[depth[VAW-1:0] - VAW'(1)];
    end else if (cmd.op == OP_EDGE && !(status.edge_match && !status.next_visited)) begin
      top_k <= top_k + ETW'(1);
    end
    if (cmd.op == OP_FREAD) fin_rd <= fin_mem[fsp[VAW-1:0]];
    if (cmd.op == OP_POP && !cmd.reversed && fsp < DTW'(MAX_VERTICES))
      fin_mem[fsp[VAW-1:0]] <= top_v;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      drop_flag <= 1'b0;
      fsp <= '0;
      depth <= '0;
      outer <= '0;
      visited <= '0;
    end else begin
      depth <= depth_next;
      if (load_en && load_has) begin
        if (load_ok) edge_total <= edge_total + ETW'(1);
        else drop_flag <= 1'b1;
      end
      case (cmd.op)
        OP_ROOT: visited[push_v[VAW-1:0]] <= 1'b1;
        OP_EDGE: if (status.edge_match && !status.next_visited)
          visited[nxt[VAW-1:0]] <= 1'b1;
        OP_POP: if (!cmd.reversed && fsp < DTW'(MAX_VERTICES)) fsp <= fsp + DTW'(1);
        OP_NEXTV: outer <= outer + CountWidth'(1);
        OP_FPOP: fsp <= fsp - DTW'(1);
        OP_CLEARV: begin
          visited <= '0;
          outer <= '0;
        end
        OP_CLEARR: begin
          edge_total <= '0;
          drop_flag <= 1'b0;
          fsp <= '0;
          visited <= '0;
        end
        default: ;
      endcase
    end
  end

  // Emit on preorder visit in the reversed pass
  always_comb begin
    emit = 1'b0;
    emit_vertex = push_v;
    if (cmd.reversed && cmd.op == OP_ROOT) emit = 1'b1;
    if (cmd.reversed && do_push) begin
      emit = 1'b1;
      emit_vertex = nxt;
    end
  end
endmodule

/* rtl/scc_ctrl.sv */
// ---------------------------------------------------------------------------
// scc_ctrl: sequencer for the two Kosaraju passes
// Issues datapath commands and stalls while the output slot is full.
// ---------------------------------------------------------------------------
module scc_ctrl import scc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  input  logic    out_busy,
  output cmd_t    cmd,
  output logic    idle,
  output logic    pass2,
  output logic    comp_close,
  output logic    run_close
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_OUTER  = 11'b00000000010,
    S_TOPRD  = 11'b00000000100,
    S_SCAN   = 11'b00000001000,
    S_EDGE   = 11'b00000010000,
    S_FPOP   = 11'b00000100000,
    S_FREAD  = 11'b00001000000,
    S_FCHK   = 11'b00010000000,
    S_CLEAR  = 11'b00100000000,
    S_START2 = 11'b01000000000,
    S_WAIT   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic rev, rev_next;

  assign idle = state == S_IDLE;
  assign pass2 = rev;

  // Next state and command
  always_comb begin
    state_next = state;
    rev_next = rev;
    cmd.op = OP_NONE;
    cmd.reversed = rev;
    comp_close = 1'b0;
    run_close = 1'b0;
    case (state)
      S_IDLE: if (start) begin
        state_next = S_OUTER; rev_next = 1'b0; cmd.op = OP_CLEARV;
      end
      S_OUTER: begin
        if (status.root_done) begin
          state_next = S_START2; cmd.op = OP_CLEARV;
        end else if (status.root_visited) begin
          cmd.op = OP_NEXTV;
        end else begin
          cmd.op = OP_ROOT; state_next = S_TOPRD;
        end
      end
      S_START2: begin
        rev_next = 1'b1; state_next = S_FPOP;
      end
      S_TOPRD: begin
        if (status.depth_zero) begin
          if (rev) begin
            comp_close = 1'b1;
            state_next = S_FPOP;
          end else begin
            cmd.op = OP_NEXTV; state_next = S_OUTER;
          end
        end else begin
          cmd.op = OP_TOPRD; state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_end) begin
          cmd.op = OP_POP; state_next = S_TOPRD;
        end else begin
          cmd.op = OP_SCAN; state_next = S_EDGE;
        end
      end
      S_EDGE: if (!out_busy) begin
        cmd.op = OP_EDGE;
        state_next = (status.edge_match && !status.next_visited) ? S_TOPRD : S_SCAN;
      end
      S_FPOP: begin
        if (status.fstack_empty) begin
          // Hold the final mark until the slot has drained
          if (!out_busy) begin
            run_close = 1'b1; state_next = S_CLEAR;
          end
        end else begin
          cmd.op = OP_FPOP; state_next = S_FREAD;
        end
      end
      S_FREAD: begin
        cmd.op = OP_FREAD; state_next = S_FCHK;
      end
      S_FCHK: begin
        if (!status.ftop_ok) state_next = S_FPOP;
        else if (!out_busy) begin
          cmd.op = OP_ROOT; state_next = S_TOPRD;
        end
      end
      S_CLEAR: if (!out_busy) begin
        cmd.op = OP_CLEARR; state_next = S_WAIT;
      end
      S_WAIT: if (!out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rev <= 1'b0;
    end else begin
      state <= state_next;
      rev <= rev_next;
    end
  end
endmodule

/* rtl/strongly_connected_components.sv */
// ---------------------------------------------------------------------------
// strongly_connected_components: Kosaraju SCC engine
// Edges load at one item per cycle while idle; the last item runs both passes.
// ---------------------------------------------------------------------------
// Edge items are taken one per cycle while the block is idle and no result
// is pending. The item marked last_edge starts the two depth-first passes.
// Each pass does a registered memory read and an evaluate step on every
// stored edge for every visited vertex, plus top reads and pops for each
// vertex, and any output stalls lengthen a run. No new item is taken until
// the whole run has been delivered. Each result goes through a one-entry
// output slot; a result is held back one slot so that the component-end and
// run-last marks can be added when the following event is known.
module strongly_connected_components import scc_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDefault,
  parameter int MAX_EDGES = MaxEdgesDefault
) (
  input logic clk,
  input logic rst,
  scc_if.sink   in_ch,
  scc_if.sink   cfg,
  scc_if.source out_ch
);
  typedef struct packed {
    logic [VertexWidth-1:0] src_vertex;
    logic [VertexWidth-1:0] dst_vertex;
    logic has_edge;
    logic last_edge;
  } in_t;
  typedef struct packed {
    logic [VertexWidth-1:0] vertex;
    logic component_end;
    logic run_last;
    logic edges_dropped;
  } out_t;

  in_t in_item;
  assign in_item = in_ch.data;

  logic [CountWidth-1:0] vertex_count;
  cmd_t cmd;
  status_t status;
  logic idle, pass2, comp_close, run_close, emit, drop_flag;
  logic [VertexWidth-1:0] emit_vertex;
  logic in_fire, start;

  // Pending result held until its marks are known
  logic hold_valid;
  logic [VertexWidth-1:0] hold_vertex;
  logic hold_end;
  out_t slot;
  logic slot_valid;
  logic out_busy;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = idle && !slot_valid && !hold_valid;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign start = in_fire && in_item.last_edge;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) vertex_count <= CountReset;
    else if (cfg.valid) vertex_count <= cfg.data;
  end

  scc_ctrl u_ctrl (
    .clk, .rst, .start, .status, .out_busy, .cmd, .idle, .pass2,
    .comp_close, .run_close
  );

  scc_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .cmd, .status,
    .load_en(in_fire), .load_src(in_item.src_vertex), .load_dst(in_item.dst_vertex),
    .load_has(in_item.has_edge), .vertex_count, .emit, .emit_vertex, .drop_flag
  );

  // Slot full blocks any event that would push the held result out
  assign out_busy = slot_valid;

  // Advance held result into the output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      slot_valid <= 1'b0;
    end else begin
      if (emit) begin
        hold_vertex <= emit_vertex;
        hold_end <= 1'b0;
        hold_valid <= 1'b1;
        if (hold_valid) begin
          slot <= '{hold_vertex, hold_end, 1'b0, drop_flag};
          slot_valid <= 1'b1;
        end else if (out_ch.valid && out_ch.ready) begin
          slot_valid <= 1'b0;
        end
      end else if (run_close && hold_valid) begin
        slot <= '{hold_vertex, 1'b1, 1'b1, drop_flag};
        slot_valid <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        if (comp_close && hold_valid) hold_end <= 1'b1;
        if (out_ch.valid && out_ch.ready) slot_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid = slot_valid;
  assign out_ch.data = slot;

  // Input is never taken during a run
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    !idle |-> !in_ch.ready) else $error("item accepted during run");
  // Emission only in the reversed pass
  a_emit_pass2: assert property (@(posedge clk) disable iff (rst)
    emit |-> pass2) else $error("emit outside second pass");
  // Held result never overwrites a full slot
  a_slot_safe: assert property (@(posedge clk) disable iff (rst)
    ((emit || run_close) && hold_valid) |-> !slot_valid) else $error("slot overrun");
endmodule

/* sim/tb_strongly_connected_components.sv */
// ---------------------------------------------------------------------------
// tb_strongly_connected_components: testbench for the Kosaraju SCC engine
// Loads directed graphs edge by edge, predicts the component stream with a
// behavioral Kosaraju search, and checks every result item in order while
// both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_strongly_connected_components;
  import scc_pkg::*;

  localparam int NumVert = MaxVerticesDefault;
  localparam int NumEdge = MaxEdgesDefault;
  localparam int WatchLimit = 200000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [VertexWidth-1:0] src_vertex;
    logic [VertexWidth-1:0] dst_vertex;
    logic                   has_edge;
    logic                   last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [VertexWidth-1:0] vertex;
    logic                   component_end;
    logic                   run_last;
    logic                   edges_dropped;
  } comp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scc_if #(.payload_t(edge_item_t))            in_ch ();
  scc_if #(.payload_t(logic [CountWidth-1:0])) cfg ();
  scc_if #(.payload_t(comp_item_t))            out_ch ();

  strongly_connected_components dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [VertexWidth-1:0] edge_src_mem [NumEdge];
  logic [VertexWidth-1:0] edge_dst_mem [NumEdge];
  int                     edge_cnt;
  bit                     drop_seen;
  logic [CountWidth-1:0]  count_reg;
  bit                     seen_mark [NumVert];
  int                     finish_q [$];
  int                     comp_q [$];
  comp_item_t             comp_expect_q [$];

  int  error_count = 0;
  int  items_sent = 0;
  bit  calm = 1'b0;
  bit  hold_start = 1'b0;
  int  hold_left = 0;
  int  idle_count = 0;

  task automatic report(input string what, input comp_item_t got, input comp_item_t want);
    $display("MISMATCH %s: got %0d/%0b/%0b/%0b want %0d/%0b/%0b/%0b",
             what, got.vertex, got.component_end, got.run_last, got.edges_dropped,
             want.vertex, want.component_end, want.run_last, want.edges_dropped);
    error_count++;
  endtask

  // Depth-first search; forward fills the finish order, reversed collects preorder
  function automatic void dfs(int root, bit rev, int cnt);
    int vstack [$];
    int pstack [$];
    int u, k, a, b, here, nxt;
    bit pushed;
    seen_mark[root] = 1'b1;
    if (rev) comp_q.insert(comp_q.size(), root);
    vstack.insert(vstack.size(), root);
    pstack.insert(pstack.size(), 0);
    while (vstack.size() > 0) begin
      u = vstack[$];
      k = pstack[$];
      pushed = 1'b0;
      for (; k < edge_cnt; k++) begin
        a = edge_src_mem[k];
        b = edge_dst_mem[k];
        here = rev ? b : a;
        nxt = rev ? a : b;
        if (a >= cnt || b >= cnt || here != u) continue;
        if (!seen_mark[nxt]) begin
          pstack[pstack.size()-1] = k + 1;
          seen_mark[nxt] = 1'b1;
          if (rev) comp_q.insert(comp_q.size(), nxt);
          vstack.insert(vstack.size(), nxt);
          pstack.insert(pstack.size(), 0);
          pushed = 1'b1;
          break;
        end
      end
      if (!pushed) begin
        void'(vstack.pop_back());
        void'(pstack.pop_back());
        if (!rev) finish_q.insert(finish_q.size(), u);
      end
    end
  endfunction

  // Apply one accepted edge item and queue the components it causes
  function automatic void predict_item(edge_item_t it);
    int cnt, top;
    comp_item_t r;
    cnt = (count_reg > NumVert) ? NumVert : count_reg;
    if (it.has_edge) begin
      if (it.src_vertex < cnt && it.dst_vertex < cnt && edge_cnt < NumEdge) begin
        edge_src_mem[edge_cnt] = it.src_vertex;
        edge_dst_mem[edge_cnt] = it.dst_vertex;
        edge_cnt++;
      end else begin
        drop_seen = 1'b1;
      end
    end
    if (!it.last_edge) return;
    foreach (seen_mark[i]) seen_mark[i] = 1'b0;
    finish_q.delete();
    for (int v = 0; v < cnt; v++)
      if (!seen_mark[v]) dfs(v, 1'b0, cnt);
    foreach (seen_mark[i]) seen_mark[i] = 1'b0;
    while (finish_q.size() > 0) begin
      top = finish_q.pop_back();
      if (top < cnt && !seen_mark[top]) begin
        comp_q.delete();
        dfs(top, 1'b1, cnt);
        foreach (comp_q[i]) begin
          r.vertex = VertexWidth'(comp_q[i]);
          r.component_end = (i == comp_q.size() - 1);
          r.run_last = 1'b0;
          r.edges_dropped = drop_seen;
          comp_expect_q.insert(comp_expect_q.size(), r);
        end
      end
    end
    if (cnt > 0) comp_expect_q[comp_expect_q.size()-1].run_last = 1'b1;
    edge_cnt = 0;
    drop_seen = 1'b0;
  endfunction

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    comp_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (comp_expect_q.size() == 0) begin
        report("unexpected item", out_ch.data, '0);
      end else begin
        want = comp_expect_q.pop_front();
        if (out_ch.data !== want) report("field", out_ch.data, want);
      end
    end
  end

  // Drive result ready: random stalls, calm stretches and a long hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  // Stop the run when nothing is accepted for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_item(input edge_item_t it);
    if (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it);
    items_sent++;
  endtask

  task automatic send_edge(input int s, input int d, input bit has, input bit last);
    edge_item_t it;
    it.src_vertex = VertexWidth'(s);
    it.dst_vertex = VertexWidth'(d);
    it.has_edge = has;
    it.last_edge = last;
    send_item(it);
  endtask

  // Lower valid, wait for every expected item, then let the block settle
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (comp_expect_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    settle();
    cfg.valid <= 1'b1;
    cfg.data <= CountWidth'(value);
    do @(posedge clk); while (!cfg.ready);
    count_reg = CountWidth'(value);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    // cycle, chain and self-loop under the reset count
    send_edge(0, 1, 1, 0);
    send_edge(1, 2, 1, 0);
    send_edge(2, 0, 1, 0);
    send_edge(2, 3, 1, 0);
    send_edge(63, 63, 1, 0);
    send_edge(63, 0, 1, 0);
    send_edge(5, 5, 0, 0);
    send_edge(3, 4, 1, 1);
    // range drop and terminator without edge
    write_count(5);
    send_edge(4, 0, 1, 0);
    send_edge(0, 4, 1, 0);
    send_edge(10, 0, 1, 0);
    send_edge(0, 63, 1, 0);
    send_edge(0, 0, 0, 1);
    // count lowered during loading
    write_count(64);
    send_edge(0, 40, 1, 0);
    send_edge(40, 0, 1, 0);
    send_edge(1, 0, 1, 0);
    write_count(2);
    send_edge(0, 1, 1, 1);
    // zero count drops everything and returns nothing
    write_count(0);
    send_edge(0, 0, 1, 0);
    send_edge(0, 0, 1, 1);
    // above the maximum acts as the maximum
    write_count(127);
    send_edge(62, 63, 1, 0);
    send_edge(63, 62, 1, 1);
    // single vertex
    write_count(1);
    send_edge(0, 0, 1, 1);
  endtask

  task automatic test_capacity();
    write_count(2);
    for (int i = 0; i < NumEdge + 3; i++)
      send_edge($urandom_range(1), $urandom_range(1), 1, i == NumEdge + 2);
  endtask

  task automatic random_graph(input int nedges);
    int cnt, lim;
    bit has;
    cnt = (count_reg > NumVert) ? NumVert : count_reg;
    lim = (cnt == 0) ? 0 : cnt - 1;
    for (int i = 0; i <= nedges; i++) begin
      has = (i == nedges) ? 1'($urandom_range(1)) : ($urandom_range(99) >= 5);
      if ($urandom_range(99) < 90)
        send_edge($urandom_range(lim), $urandom_range(lim), has, i == nedges);
      else
        send_edge($urandom_range(63), $urandom_range(63), has, i == nedges);
    end
  endtask

  task automatic test_random();
    int sel;
    while (items_sent < 400) begin
      sel = $urandom_range(9);
      case (sel)
        0: write_count(1);
        1: write_count(64);
        2: write_count(0);
        3: write_count(127);
        4: write_count($urandom_range(127));
        default: write_count($urandom_range(64, 1));
      endcase
      calm = ($urandom_range(5) == 0);
      random_graph(($urandom_range(19) == 0) ? $urandom_range(200, 60) : $urandom_range(30));
      calm = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    write_count(64);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 8; i++) send_edge(i, (i + 1) % 8, 1, 0);
      send_edge(0, 0, 0, 1);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    out_ch.ready = 1'b0;
    edge_cnt = 0;
    drop_seen = 1'b0;
    count_reg = CountReset;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random();
    settle();
    repeat (50) @(posedge clk);
    if (error_count == 0 && comp_expect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
